// ----- src/bst_pkg.sv -----
package bst_pkg;

  // Parser modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_SLEN  = 3'd2;
  localparam logic [2:0] MODE_SDATA = 3'd3;
  localparam logic [2:0] MODE_DONE  = 3'd4;

  // Token kinds
  localparam logic [2:0] TK_NONE     = 3'd0;
  localparam logic [2:0] TK_INT      = 3'd1;
  localparam logic [2:0] TK_STR_LEN  = 3'd2;
  localparam logic [2:0] TK_STR_DATA = 3'd3;
  localparam logic [2:0] TK_LIST     = 3'd4;
  localparam logic [2:0] TK_DICT     = 3'd5;
  localparam logic [2:0] TK_CLOSE    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_PEND     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // Integer flag bit positions
  localparam int FL_NEG   = 0;
  localparam int FL_SIGN  = 1;
  localparam int FL_DIGIT = 2;
  localparam int FL_ZERO  = 3;

  // Syntax bytes
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int COUNT_BITS = 32;

  // Stack operation for one transaction
  typedef struct packed {
    logic clear;
    logic push;
    logic push_kind;  // 1 = dict
    logic pop;
    logic toggle;
  } stk_cmd_t;

  // One result item
  typedef struct packed {
    logic [2:0]            token_kind;
    logic [63:0]           token_value;
    logic [5:0]            nest_level;
    logic                  is_key;
    logic                  string_end;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] end_offset;
  } result_t;

endpackage

// ----- src/bst_stack.sv -----
module bst_stack
  import bst_pkg::*;
#(
  parameter int  MAX_DEPTH = 32,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_cmd_t      cmd,
  output logic [DW-1:0] depth,
  output logic          top_kind,
  output logic          top_parity
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [DW-1:0] depth_r, depth_nxt;
  logic          top_kind_r, top_kind_nxt;
  logic          top_parity_r, top_parity_nxt;
  logic [1:0]    mem [MAX_DEPTH];
  logic [1:0]    rd_data_r;
  logic [DW-1:0] wr_ptr, rd_ptr;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          we;
  logic [1:0]    wdata;

  // Entries below the top live in memory; the top lives in flops.
  // rd_data_r always holds the entry just under the top.
  always_comb begin
    depth_nxt      = depth_r;
    top_kind_nxt   = top_kind_r;
    top_parity_nxt = top_parity_r;
    if (cmd.clear) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt      = depth_r + DW'(1);
      top_kind_nxt   = cmd.push_kind;
      top_parity_nxt = 1'b0;
    end else if (cmd.pop) begin
      depth_nxt      = depth_r - DW'(1);
      top_kind_nxt   = rd_data_r[1];
      top_parity_nxt = rd_data_r[0];
    end else if (cmd.toggle) begin
      top_parity_nxt = ~top_parity_r;
    end
  end

  // Old top goes down with its child count bumped by the open
  assign we      = cmd.push && (depth_r != '0);
  assign wdata   = {top_kind_r, ~top_parity_r};
  assign wr_ptr  = depth_r - DW'(1);
  assign rd_ptr  = depth_nxt - DW'(2);
  assign wr_addr = wr_ptr[AW-1:0];
  assign rd_addr = rd_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    if (we && (wr_addr == rd_addr)) begin
      rd_data_r <= wdata;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_kind_r   <= top_kind_nxt;
    top_parity_r <= top_parity_nxt;
  end

  assign depth      = depth_r;
  assign top_kind   = top_kind_r;
  assign top_parity = top_parity_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("stack depth beyond limit");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && !cmd.clear |-> depth_r < DW'(MAX_DEPTH))
    else $error("push on full stack");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && !cmd.clear |=> depth_r == $past(depth_r) - DW'(1))
    else $error("pop did not lower depth");
`endif

endmodule

// ----- src/bst_parse.sv -----
module bst_parse
  import bst_pkg::*;
#(
  parameter int  MAX_DEPTH   = 32,
  parameter int  LENGTH_BITS = 32,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [DW-1:0] depth,
  input  logic          top_kind,
  input  logic          top_parity,
  output stk_cmd_t      cmd,
  output result_t       res
);

  localparam int          LW      = (DW > 6) ? DW : 6;
  localparam logic [67:0] LEN_LIM = (68'd1 << LENGTH_BITS) - 68'd1;

  logic [2:0]             mode_r, mode_nxt;
  logic [63:0]            accum_r, accum_nxt;
  logic [3:0]             flags_r, flags_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  logic        digit, key_pos, lvl_open;
  logic [3:0]  dig;
  logic [67:0] prod, int_lim;
  logic [LW-1:0] lvl;
  stk_cmd_t    c;
  result_t     r;

  assign digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign dig     = data_byte[3:0];
  assign key_pos = (depth != '0) && top_kind && !top_parity;

  // Shared multiply-by-ten accumulate
  assign prod    = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + 68'(dig);
  assign int_lim = {4'b0, flags_r[FL_NEG] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF};

  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    flags_nxt = flags_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    c         = '0;
    r         = '0;
    r.status  = ST_PEND;
    lvl_open  = 1'b0;

    if (mode_r == MODE_DONE) begin
      r.status = ST_IGNORED;
    end else begin
      count_nxt = count_r + COUNT_BITS'(1);
      unique case (mode_r)
        MODE_IDLE: begin
          if (data_byte == CH_I) begin
            if (key_pos) begin
              r.status = ST_ERROR;
            end else begin
              mode_nxt  = MODE_INT;
              accum_nxt = '0;
              flags_nxt = '0;
            end
          end else if (data_byte == CH_L || data_byte == CH_D) begin
            if (key_pos || depth >= DW'(MAX_DEPTH)) begin
              r.status = ST_ERROR;
            end else begin
              c.push       = 1'b1;
              c.push_kind  = (data_byte == CH_D);
              lvl_open     = 1'b1;
              r.token_kind = (data_byte == CH_D) ? TK_DICT : TK_LIST;
            end
          end else if (data_byte == CH_E) begin
            if (depth == '0 || (top_kind && top_parity)) begin
              r.status = ST_ERROR;
            end else begin
              c.pop        = 1'b1;
              r.token_kind = TK_CLOSE;
              if (depth == DW'(1)) r.status = ST_COMPLETE;
            end
          end else if (digit) begin
            // one digit never exceeds the length limit when LENGTH_BITS is at least 4
            mode_nxt  = MODE_SLEN;
            accum_nxt = 64'(dig);
          end
        end
        MODE_INT: begin
          if ((data_byte == CH_MINUS || data_byte == CH_PLUS) &&
              !flags_r[FL_SIGN] && !flags_r[FL_DIGIT]) begin
            flags_nxt[FL_SIGN] = 1'b1;
            flags_nxt[FL_NEG]  = (data_byte == CH_MINUS);
          end else if (digit) begin
            if (!flags_r[FL_DIGIT] && dig == 4'd0) flags_nxt[FL_ZERO] = 1'b1;
            flags_nxt[FL_DIGIT] = 1'b1;
            if (prod > int_lim) begin
              r.status = ST_ERROR;
            end else begin
              accum_nxt = prod[63:0];
            end
          end else if (data_byte == CH_E) begin
            // empty body or nonzero value with a leading zero
            if (!flags_r[FL_DIGIT] || (flags_r[FL_ZERO] && accum_r != '0)) begin
              r.status = ST_ERROR;
            end else begin
              r.token_kind  = TK_INT;
              r.token_value = flags_r[FL_NEG] ? (64'd0 - accum_r) : accum_r;
              c.toggle      = 1'b1;
              mode_nxt      = MODE_IDLE;
              if (depth == '0) r.status = ST_COMPLETE;
            end
          end else begin
            r.status = ST_ERROR;
          end
        end
        MODE_SLEN: begin
          if (digit) begin
            if (prod > LEN_LIM) begin
              r.status = ST_ERROR;
            end else begin
              accum_nxt = prod[63:0];
            end
          end else if (data_byte == CH_COLON) begin
            r.token_kind  = TK_STR_LEN;
            r.token_value = accum_r;
            r.is_key      = key_pos;
            if (accum_r == '0) begin
              r.string_end = 1'b1;
              c.toggle     = 1'b1;
              mode_nxt     = MODE_IDLE;
              if (depth == '0) r.status = ST_COMPLETE;
            end else begin
              left_nxt = accum_r[LENGTH_BITS-1:0];
              mode_nxt = MODE_SDATA;
            end
          end else begin
            r.status = ST_ERROR;
          end
        end
        MODE_SDATA: begin
          r.token_kind  = TK_STR_DATA;
          r.token_value = {56'd0, data_byte};
          r.is_key      = key_pos;
          if (left_r <= LENGTH_BITS'(1)) begin
            left_nxt     = '0;
            r.string_end = 1'b1;
            c.toggle     = 1'b1;
            mode_nxt     = MODE_IDLE;
            if (depth == '0) r.status = ST_COMPLETE;
          end else begin
            left_nxt = left_r - LENGTH_BITS'(1);
          end
        end
        default: begin
          r.status = ST_ERROR;
        end
      endcase
    end

    // Buffer ends before the value does
    if (r.status == ST_PEND && last_byte) r.status = ST_ERROR;
    if (r.status == ST_COMPLETE || r.status == ST_ERROR) mode_nxt = MODE_DONE;

    // Open reports depth before push, close depth after pop
    lvl          = c.pop ? LW'(depth - DW'(1)) : LW'(depth);
    if (lvl_open) lvl = LW'(depth);
    r.nest_level = lvl[5:0];
    r.end_offset = (r.status == ST_COMPLETE) ? count_nxt : '0;

    // Self-reset after the final byte
    if (last_byte) begin
      mode_nxt  = MODE_IDLE;
      accum_nxt = '0;
      flags_nxt = '0;
      left_nxt  = '0;
      count_nxt = '0;
      c.clear   = 1'b1;
    end
  end

  assign cmd = adv ? c : '0;
  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      accum_r <= '0;
      flags_r <= '0;
      left_r  <= '0;
      count_r <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      flags_r <= flags_nxt;
      left_r  <= left_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- src/bencode_stream_tokenizer_core.sv -----
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   data_byte, last_byte
// out_     output     out_valid/out_ready token_kind, token_value, nest_level,
//                                         is_key, string_end, status, end_offset
//
// One byte per cycle sustained while out_ready is high; a byte passes the input
// register, then the result register, a split set by the multiply-by-ten accumulate
// and the stack top. rst_n is synchronous; the block also returns to its reset state
// after a transaction with last_byte set. Stack memory needs no clearing pass.
// A stall on out_ready holds both stages; in_ready drops only when both are full.
module bencode_stream_tokenizer_core
  import bst_pkg::*;
#(
  parameter int MAX_DEPTH   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_token_kind,
  output logic signed [63:0]    out_token_value,
  output logic [5:0]            out_nest_level,
  output logic                  out_is_key,
  output logic                  out_string_end,
  output logic [1:0]            out_status,
  output logic [COUNT_BITS-1:0] out_end_offset
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r;
  logic          s1_adv, s1_fire, in_fire;
  logic [DW-1:0] depth;
  logic          top_kind, top_parity;
  stk_cmd_t      cmd;
  result_t       res;

  // Handshake between the two stages
  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  bst_parse #(
    .MAX_DEPTH   (MAX_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (s1_fire),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .depth      (depth),
    .top_kind   (top_kind),
    .top_parity (top_parity),
    .cmd        (cmd),
    .res        (res)
  );

  bst_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .depth      (depth),
    .top_kind   (top_kind),
    .top_parity (top_parity)
  );

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_res_r.token_kind;
  assign out_token_value = out_res_r.token_value;
  assign out_nest_level  = out_res_r.nest_level;
  assign out_is_key      = out_res_r.is_key;
  assign out_string_end  = out_res_r.string_end;
  assign out_status      = out_res_r.status;
  assign out_end_offset  = out_res_r.end_offset;

`ifndef SYNTHESIS
  a_ignored_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_IGNORED |-> out_token_kind == TK_NONE)
    else $error("token reported on ignored byte");
  a_key_only_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_key |->
      (out_token_kind == TK_STR_LEN || out_token_kind == TK_STR_DATA))
    else $error("key flag on non-string token");
  a_offset_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_COMPLETE |-> out_end_offset == '0)
    else $error("end offset without completion");
`endif

endmodule

// ----- bench/bst_token_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts every token from the
// accepted bytes and compares the returned tokens in order.
module bst_token_checker
  import bst_pkg::*;
#(
  parameter int MAX_DEPTH   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            out_token_kind,
  input  logic [63:0]           out_token_value,
  input  logic [5:0]            out_nest_level,
  input  logic                  out_is_key,
  input  logic                  out_string_end,
  input  logic [1:0]            out_status,
  input  logic [COUNT_BITS-1:0] out_end_offset,
  output int                    mismatch_count,
  output int                    tokens_due
);

  localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 64) ? {64{1'b1}}
                                    : ((64'd1 << LENGTH_BITS) - 64'd1);

  // predictor state
  logic                  ctr_kind [0:MAX_DEPTH-1];  // 1 = dict
  logic                  ctr_par  [0:MAX_DEPTH-1];  // child count parity
  logic [31:0]           depth;
  logic [2:0]            pmode;
  logic [63:0]           accum;
  logic [3:0]            iflags;
  logic [63:0]           remaining;
  logic [COUNT_BITS-1:0] nbytes;

  result_t expected_tokens [$];

  function automatic logic at_key();
    if (depth == 0 || depth > MAX_DEPTH) return 1'b0;
    return ctr_kind[depth-1] && !ctr_par[depth-1];
  endfunction

  task automatic bump_parity();
    if (depth > 0 && depth <= MAX_DEPTH) ctr_par[depth-1] = !ctr_par[depth-1];
  endtask

  task automatic clear_parser();
    for (int i = 0; i < MAX_DEPTH; i++) begin
      ctr_kind[i] = 1'b0;
      ctr_par[i]  = 1'b0;
    end
    depth     = 0;
    pmode     = MODE_IDLE;
    accum     = '0;
    iflags    = '0;
    remaining = '0;
    nbytes    = '0;
  endtask

  // Advance the parser by one byte and return the token it yields
  task automatic tokenize_byte(input logic [7:0] b, input logic last, output result_t r);
    logic [2:0]  kind;
    logic [63:0] val;
    logic [5:0]  lvl;
    logic        key;
    logic        send;
    logic [1:0]  st;
    logic        lvl_set;
    logic        digit;
    logic [63:0] d;
    logic [63:0] lim;
    kind    = TK_NONE;
    val     = '0;
    lvl     = '0;
    key     = 1'b0;
    send    = 1'b0;
    st      = ST_PEND;
    lvl_set = 1'b0;
    digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    d       = {56'd0, b} - {56'd0, CH_ZERO};

    if (pmode == MODE_DONE) begin
      st = ST_IGNORED;
    end else begin
      nbytes = nbytes + 1;
      case (pmode)
        MODE_IDLE: begin
          if (b == CH_I) begin
            if (at_key()) st = ST_ERROR;
            else begin
              pmode  = MODE_INT;
              accum  = '0;
              iflags = '0;
            end
          end else if (b == CH_L || b == CH_D) begin
            if (at_key() || depth >= MAX_DEPTH) st = ST_ERROR;
            else begin
              bump_parity();
              lvl             = depth[5:0];
              lvl_set         = 1'b1;
              ctr_kind[depth] = (b == CH_D);
              ctr_par[depth]  = 1'b0;
              depth           = depth + 1;
              kind            = (b == CH_D) ? TK_DICT : TK_LIST;
            end
          end else if (b == CH_E) begin
            if (depth == 0 || depth > MAX_DEPTH) st = ST_ERROR;
            else if (ctr_kind[depth-1] && ctr_par[depth-1]) st = ST_ERROR;  // odd dict
            else begin
              depth = depth - 1;
              kind  = TK_CLOSE;
              if (depth == 0) st = ST_COMPLETE;
            end
          end else if (digit) begin
            pmode = MODE_SLEN;
            accum = d;
            if (accum > LEN_MAX) st = ST_ERROR;
          end
        end
        MODE_INT: begin
          if ((b == CH_MINUS || b == CH_PLUS) && !iflags[FL_SIGN] && !iflags[FL_DIGIT]) begin
            iflags[FL_SIGN] = 1'b1;
            if (b == CH_MINUS) iflags[FL_NEG] = 1'b1;
          end else if (digit) begin
            lim = iflags[FL_NEG] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (!iflags[FL_DIGIT] && d == 0) iflags[FL_ZERO] = 1'b1;
            iflags[FL_DIGIT] = 1'b1;
            if (accum > (lim - d) / 64'd10) st = ST_ERROR;
            else accum = accum * 64'd10 + d;
          end else if (b == CH_E) begin
            if (!iflags[FL_DIGIT] || (iflags[FL_ZERO] && accum != 0)) st = ST_ERROR;
            else begin
              kind = TK_INT;
              val  = iflags[FL_NEG] ? (64'd0 - accum) : accum;
              bump_parity();
              pmode = MODE_IDLE;
              if (depth == 0) st = ST_COMPLETE;
            end
          end else begin
            st = ST_ERROR;
          end
        end
        MODE_SLEN: begin
          if (digit) begin
            if (accum > (LEN_MAX - d) / 64'd10) st = ST_ERROR;
            else accum = accum * 64'd10 + d;
          end else if (b == CH_COLON) begin
            kind = TK_STR_LEN;
            val  = accum;
            key  = at_key();
            if (accum == 0) begin
              send = 1'b1;
              bump_parity();
              pmode = MODE_IDLE;
              if (depth == 0) st = ST_COMPLETE;
            end else begin
              remaining = accum;
              pmode     = MODE_SDATA;
            end
          end else begin
            st = ST_ERROR;
          end
        end
        default: begin
          // string data
          kind = TK_STR_DATA;
          val  = {56'd0, b};
          key  = at_key();
          if (remaining > 0) remaining = remaining - 1;
          if (remaining == 0) begin
            send = 1'b1;
            bump_parity();
            pmode = MODE_IDLE;
            if (depth == 0) st = ST_COMPLETE;
          end
        end
      endcase
    end

    if (st == ST_PEND && last) st = ST_ERROR;  // buffer ended mid-value
    if (st == ST_COMPLETE || st == ST_ERROR) pmode = MODE_DONE;
    if (!lvl_set) lvl = depth[5:0];

    r.token_kind  = kind;
    r.token_value = val;
    r.nest_level  = lvl;
    r.is_key      = key;
    r.string_end  = send;
    r.status      = st;
    r.end_offset  = (st == ST_COMPLETE) ? nbytes : '0;

    if (last) clear_parser();
  endtask

  // Compare returned tokens first, then predict the byte taken at this edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_parser();
      expected_tokens.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.token_kind  = out_token_kind;
        got.token_value = out_token_value;
        got.nest_level  = out_nest_level;
        got.is_key      = out_is_key;
        got.string_end  = out_string_end;
        got.status      = out_status;
        got.end_offset  = out_end_offset;
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%t: token with none expected: kind %0d value %0d status %0d",
                     $realtime, got.token_kind, $signed(got.token_value), got.status);
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind  !== want.token_kind  ||
              got.token_value !== want.token_value ||
              got.nest_level  !== want.nest_level  ||
              got.is_key      !== want.is_key      ||
              got.string_end  !== want.string_end  ||
              got.status      !== want.status      ||
              got.end_offset  !== want.end_offset) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%t: token mismatch", $realtime);
              $display("  expected kind %0d value %0d level %0d key %0d end %0d st %0d off %0d",
                       want.token_kind, $signed(want.token_value), want.nest_level,
                       want.is_key, want.string_end, want.status, want.end_offset);
              $display("  actual   kind %0d value %0d level %0d key %0d end %0d st %0d off %0d",
                       got.token_kind, $signed(got.token_value), got.nest_level,
                       got.is_key, got.string_end, got.status, got.end_offset);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        tokenize_byte(in_data_byte, in_last_byte, want);
        expected_tokens.push_back(want);
      end
    end
    tokens_due = expected_tokens.size();
  end

endmodule

// ----- bench/tb_bencode_stream_tokenizer_core.sv -----
`timescale 1ns / 1ps

// Feeds bencoded buffers into the tokenizer under varying back-pressure and
// reports the verdict from the checker's mismatch count.
module tb_bencode_stream_tokenizer_core;
  import bst_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 185;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic                  in_last_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_token_kind;
  logic signed [63:0]    out_token_value;
  logic [5:0]            out_nest_level;
  logic                  out_is_key;
  logic                  out_string_end;
  logic [1:0]            out_status;
  logic [COUNT_BITS-1:0] out_end_offset;

  int mismatch_count;
  int tokens_due;
  int send_idle_pct;
  int recv_stall_pct;
  int phase_items;
  int stuck_cycles;

  logic [7:0] buf_q [$];

  bencode_stream_tokenizer_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_token_value(out_token_value),
    .out_nest_level (out_nest_level),
    .out_is_key     (out_is_key),
    .out_string_end (out_string_end),
    .out_status     (out_status),
    .out_end_offset (out_end_offset)
  );

  bst_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_token_value(out_token_value),
    .out_nest_level (out_nest_level),
    .out_is_key     (out_is_key),
    .out_string_end (out_string_end),
    .out_status     (out_status),
    .out_end_offset (out_end_offset),
    .mismatch_count (mismatch_count),
    .tokens_due     (tokens_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result-side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // no transaction on either channel for too long ends the run
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---- buffer builders ----
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
  endfunction

  function automatic void put_dec(input logic [63:0] m);
    logic [7:0]  digs [0:19];
    logic [63:0] v;
    logic [63:0] rem;
    int          n;
    n = 0;
    v = m;
    if (v == 0) begin
      digs[0] = CH_ZERO;
      n = 1;
    end
    while (v != 0) begin
      rem     = v % 64'd10;
      digs[n] = CH_ZERO + rem[7:0];
      v       = v / 64'd10;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) buf_q.push_back(digs[i]);
  endfunction

  function automatic void gen_int();
    logic [63:0] m;
    int          sgn;
    int          sz;
    sgn = $urandom_range(0, 3);
    sz  = $urandom_range(0, 3);
    case (sz)
      0: m = $urandom_range(0, 99);
      1: m = {32'd0, $urandom};
      2: begin
        m = {$urandom, $urandom} >> $urandom_range(0, 63);
        m[63] = 1'b0;
      end
      default: m = (sgn == 2) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    buf_q.push_back(CH_I);
    if (sgn == 2) buf_q.push_back(CH_MINUS);
    if (sgn == 3) buf_q.push_back(CH_PLUS);
    put_dec(m);
    buf_q.push_back(CH_E);
  endfunction

  function automatic void gen_str();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) buf_q.push_back(CH_ZERO);  // leading zero is legal
    put_dec(n);
    buf_q.push_back(CH_COLON);
    repeat (n) begin
      c = $urandom_range(0, 255);
      buf_q.push_back(c);
    end
  endfunction

  function automatic void gen_value(input int lvl);
    int pick;
    int n;
    pick = (lvl >= 4) ? $urandom_range(0, 5) : $urandom_range(0, 9);
    n    = $urandom_range(0, 3);
    if (pick < 3) gen_int();
    else if (pick < 6) gen_str();
    else if (pick < 8) begin
      buf_q.push_back(CH_L);
      repeat (n) gen_value(lvl + 1);
      buf_q.push_back(CH_E);
    end else begin
      buf_q.push_back(CH_D);
      repeat (n) begin
        gen_str();
        gen_value(lvl + 1);
      end
      buf_q.push_back(CH_E);
    end
  endfunction

  // ---- driving ----
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // tail: bytes at the end that the block only ignores
  task automatic send_buffer(input int tail);
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
    phase_items += buf_q.size() - tail;
    buf_q.delete();
  endtask

  task automatic send_text(input string s);
    put_text(s);
    send_buffer(0);
  endtask

  // one random buffer: mostly well formed, the rest broken or noise
  task automatic send_random_buffer();
    int         sel;
    int         k;
    int         tail;
    logic [7:0] c;
    sel  = $urandom_range(0, 99);
    tail = 0;
    if (sel < 60) begin
      if ($urandom_range(0, 9) == 0) buf_q.push_back(8'h20);  // skipped lead byte
      gen_value(0);
      if ($urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, 3);
        repeat (tail) begin
          c = $urandom_range(0, 255);
          buf_q.push_back(c);
        end
      end
    end else if (sel < 70) begin
      // truncated value
      gen_value(0);
      if (buf_q.size() > 1) begin
        k = $urandom_range(1, buf_q.size() - 1);
        repeat (k) void'(buf_q.pop_back());
      end
    end else if (sel < 80) begin
      // one corrupted byte
      gen_value(0);
      k = $urandom_range(0, buf_q.size() - 1);
      c = $urandom_range(0, 255);
      buf_q[k] = c;
    end else if (sel < 88) begin
      // deep nesting around the stack limit
      k = $urandom_range(28, 34);
      repeat (k) buf_q.push_back(CH_L);
      if ($urandom_range(0, 1) == 1) gen_int();
      repeat (k) buf_q.push_back(CH_E);
    end else if (sel < 94) begin
      // dict key errors and odd close
      if ($urandom_range(0, 1) == 1) buf_q.push_back(CH_L);
      buf_q.push_back(CH_D);
      case ($urandom_range(0, 2))
        0: gen_int();
        1: gen_str();
        default: begin
          gen_str();
          gen_value(1);
        end
      endcase
      buf_q.push_back(CH_E);
      buf_q.push_back(CH_E);
    end else begin
      // noise
      k = $urandom_range(1, 8);
      repeat (k) begin
        c = $urandom_range(0, 255);
        buf_q.push_back(c);
      end
    end
    send_buffer(tail);
  endtask

  // ---- main sequence ----
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_items    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed cases
    send_text("i9223372036854775807e");
    send_text("i-9223372036854775808e");
    send_text("i9223372036854775808e");  // magnitude overflow
    send_text("i03e");                   // leading zero
    send_text("ie");                     // empty body
    send_text("i+5e");
    send_text("i5-e");                   // sign after digit
    send_text("i--5e");                  // second sign
    send_text("i1xe");                   // non-digit in body
    send_text("0:");                     // empty string
    send_text("4294967295:");            // max length, then cut short
    send_text("4294967296");             // length overflow
    send_text("1x");                     // bad length character
    send_text("le");
    send_text("de");
    send_text("d3:keyi1ee");
    send_text("di1ei2ee");               // integer in key position
    send_text("d1:ae");                  // dict closed after a key only
    send_text("e");                      // close at depth zero
    send_text("l");                      // incomplete
    send_text("i1eXYZ");                 // bytes after completion
    send_text(" i7e");                   // skipped leading byte
    put_text("3:");
    buf_q.push_back(8'h00);
    buf_q.push_back(8'hFF);
    buf_q.push_back(8'h80);
    send_buffer(0);
    repeat (33) buf_q.push_back(CH_L);   // stack overflow
    send_buffer(0);

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_buffer();
    end

    in_valid = 1'b0;
    while (tokens_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bst_pkg.sv
src/bst_stack.sv
src/bst_parse.sv
src/bencode_stream_tokenizer_core.sv
bench/bst_token_checker.sv
bench/tb_bencode_stream_tokenizer_core.sv
